### design/ifs_pkg.sv
// Shared types and constants for the integer field scanner.
`default_nettype none

package ifs_pkg;

    // Character limit of one field (the field ends after FIELD_LIMIT-1 characters)
    localparam int FIELD_LIMIT = 64;
    localparam int LEN_W       = 6;
    localparam logic [LEN_W-1:0] LAST_TAKEN = LEN_W'(FIELD_LIMIT - 1);

    // Widths of the stream payloads
    localparam int CH_W      = 8;
    localparam int VALUE_W   = 64;
    localparam int M_TDATA_W = 72;
    localparam int M_TUSER_W = 3;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 7;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BASE_MODE   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_CHARS   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIGNED_MODE = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DEST_SIZE   = 8'd3;

    // Characters
    localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CH_W-1:0] CH_LOW_A = 8'h61;
    localparam logic [CH_W-1:0] CH_LOW_Z = 8'h7A;
    localparam logic [CH_W-1:0] CH_UP_A  = 8'h41;
    localparam logic [CH_W-1:0] CH_UP_Z  = 8'h5A;
    localparam logic [CH_W-1:0] CH_LOW_X = 8'h78;
    localparam logic [CH_W-1:0] CH_UP_X  = 8'h58;
    localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CH_W-1:0] CH_CR    = 8'h0D;

    // Scan phase
    typedef enum logic [2:0] {
        PH_SKIP,
        PH_SIGN,
        PH_ZERO,
        PH_XMARK,
        PH_DIGITS
    } phase_t;

    // Number base; encoding matches the base_mode register
    typedef enum logic [1:0] {
        BASE_AUTO = 2'd0,
        BASE_OCT  = 2'd1,
        BASE_DEC  = 2'd2,
        BASE_HEX  = 2'd3
    } base_t;

    // Destination size codes
    typedef enum logic [1:0] {
        DEST_8  = 2'd0,
        DEST_16 = 2'd1,
        DEST_32 = 2'd2,
        DEST_64 = 2'd3
    } dest_t;

    // Finished field before saturation and truncation
    typedef struct packed {
        logic                ok;
        logic [VALUE_W-1:0]  mag;
        logic                negative;
        logic                overflowed;
        logic                signed_mode;
        dest_t               dest_size;
        logic [LEN_W-1:0]    length;
        logic                consumed;
        logic                at_end;
    } raw_result_t;

endpackage

`default_nettype wire

### design/integer_field_scanner_unit.sv
// Top level: scanf-style integer field scanner, one character beat per cycle when not stalled.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+----------------------------------------------
//  s_      | in  | s_tvalid/s_tready  | tdata: ch; tuser: end_of_input
//  m_      | out | m_tvalid/m_tready  | tdata: value, field_length; tuser: status,
//          |     |                    |   terminator_consumed, hit_end
//  cfg_    | in  | cfg_valid/cfg_ready| cfg_index, cfg_data (always ready)
//
// One input beat per cycle while the result path is not stalled. The scan state updates
// in the cycle a beat is taken; a beat that ends a field loads a result register, and
// the saturation/truncation stage after it registers the value that drives m_.
// The 64-bit multiply-by-base and add with overflow check sets the cycle time.
// Reset puts the scanner in the whitespace phase with default registers.
// Output stalls back up through the two result registers to s_tready.
`default_nettype none

module integer_field_scanner_unit
    import ifs_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [CH_W-1:0]      s_tdata,   // [7:0] ch
    input  wire logic                 s_tuser,   // [0] end_of_input
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,   // [63:0] value, [69:64] field_length, rest 0
    output logic [M_TUSER_W-1:0]      m_tuser,   // [0] status, [1] terminator_consumed, [2] hit_end
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_DAT_W-1:0] cfg_data
);

    // Configuration registers
    base_t               base_mode_reg;
    logic [6:0]          max_chars_reg;
    logic                signed_mode_reg;
    dest_t               dest_size_reg;

    // Scan state
    phase_t              phase_reg, phase_next;
    logic [6:0]          chars_left_reg, chars_left_next;
    logic [LEN_W-1:0]    taken_count_reg, taken_count_next;
    logic                has_digit_reg, has_digit_next;
    base_t               base_reg, base_next;
    logic                negative_reg, negative_next;
    logic [VALUE_W-1:0]  acc_reg, acc_next;
    logic                overflowed_reg, overflowed_next;

    // Result pipeline
    logic                r1_valid_reg, r1_valid_next;
    raw_result_t         r1_reg, r1_next;
    logic                out_valid_reg;
    logic [VALUE_W-1:0]  out_value_reg, out_value_next;
    logic [LEN_W-1:0]    out_len_reg;
    logic                out_status_reg, out_consumed_reg, out_at_end_reg;

    // Step signals
    logic                accept, out_ready, r1_ready, r1_advance;
    logic                eoi, is_ws, is_sign, done;
    logic                emit, consumed, at_end, take;
    logic                dig_ok, digit_take;
    logic [5:0]          digit;
    logic [4:0]          base_val;
    logic [VALUE_W+3:0]  prod, sum;
    logic [VALUE_W-1:0]  lim, r;
    logic [CH_W-1:0]     c;

    // Handshakes
    assign cfg_ready  = 1'b1;
    assign out_ready  = !out_valid_reg || m_tready;
    assign r1_advance = r1_valid_reg && out_ready;
    assign r1_ready   = !r1_valid_reg || out_ready;
    assign s_tready   = r1_ready;
    assign accept     = s_tvalid && s_tready;

    assign c     = s_tdata;
    assign eoi   = s_tuser;
    assign is_ws = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    assign is_sign = (c == CH_MINUS) || (c == CH_PLUS);

    // Digit value of the character
    always_comb
    begin
        dig_ok = 1'b1;
        digit  = '0;
        if (c >= CH_ZERO && c <= CH_NINE)
        begin
            digit = 6'(c - CH_ZERO);
        end
        else if (c >= CH_LOW_A && c <= CH_LOW_Z)
        begin
            digit = 6'(c - CH_LOW_A + 8'd10);
        end
        else if (c >= CH_UP_A && c <= CH_UP_Z)
        begin
            digit = 6'(c - CH_UP_A + 8'd10);
        end
        else
        begin
            dig_ok = 1'b0;
        end
    end

    // Multiply by base and add digit, 4 guard bits catch 64-bit overflow
    always_comb
    begin
        case (base_next)
            BASE_OCT: prod = {1'b0, acc_reg, 3'b000};
            BASE_DEC: prod = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0};
            BASE_HEX: prod = {acc_reg, 4'b0000};
            default:  prod = '0;
        endcase
        sum = prod + (VALUE_W+4)'(digit);
    end

    // Next scan state
    always_comb
    begin
        phase_next       = phase_reg;
        chars_left_next  = chars_left_reg;
        taken_count_next = taken_count_reg;
        has_digit_next   = has_digit_reg;
        base_next        = base_reg;
        negative_next    = negative_reg;
        acc_next         = acc_reg;
        overflowed_next  = overflowed_reg;
        emit       = 1'b0;
        consumed   = 1'b0;
        at_end     = 1'b0;
        done       = 1'b0;
        take       = 1'b0;
        digit_take = 1'b0;
        base_val   = 5'd0;

        // Whitespace skip; first other character latches width and base
        if (phase_reg == PH_SKIP)
        begin
            if (eoi)
            begin
                emit   = 1'b1;
                at_end = 1'b1;
                done   = 1'b1;
            end
            else if (is_ws)
            begin
                done = 1'b1;
            end
            else
            begin
                chars_left_next = max_chars_reg;
                base_next       = base_mode_reg;
                phase_next      = PH_SIGN;
            end
        end

        // Optional sign
        if (!done && phase_next == PH_SIGN)
        begin
            phase_next = PH_ZERO;
            if (!eoi && is_sign && chars_left_next > 7'd1)
            begin
                take          = 1'b1;
                negative_next = (c == CH_MINUS);
                done          = 1'b1;
            end
        end

        // Leading zero, then optional x mark
        if (!done && phase_next == PH_ZERO)
        begin
            phase_next = PH_DIGITS;
            if (!eoi && c == CH_ZERO && (base_next == BASE_AUTO || base_next == BASE_HEX)
                && chars_left_next > 7'd1)
            begin
                take           = 1'b1;
                has_digit_next = 1'b1;
                phase_next     = PH_XMARK;
                done           = 1'b1;
            end
            else if (base_next == BASE_AUTO)
            begin
                base_next = BASE_DEC;
            end
        end
        else if (!done && phase_next == PH_XMARK)
        begin
            phase_next = PH_DIGITS;
            if (!eoi && (c == CH_LOW_X || c == CH_UP_X) && chars_left_next > 7'd1)
            begin
                take           = 1'b1;
                base_next      = BASE_HEX;
                has_digit_next = 1'b0;
                done           = 1'b1;
            end
            else if (base_next == BASE_AUTO)
            begin
                base_next = BASE_OCT;
            end
        end

        // Digits
        if (!done)
        begin
            case (base_next)
                BASE_OCT: base_val = 5'd8;
                BASE_DEC: base_val = 5'd10;
                BASE_HEX: base_val = 5'd16;
                default:  base_val = 5'd0;
            endcase
            if (!eoi && chars_left_next != 7'd0 && taken_count_reg < LAST_TAKEN
                && dig_ok && digit < 6'(base_val))
            begin
                digit_take     = 1'b1;
                take           = 1'b1;
                has_digit_next = 1'b1;
                if (overflowed_reg || sum[VALUE_W+3:VALUE_W] != 4'd0)
                begin
                    overflowed_next = 1'b1;
                    acc_next        = '1;
                end
                else
                begin
                    acc_next = sum[VALUE_W-1:0];
                end
            end
            else
            begin
                emit   = 1'b1;
                at_end = eoi;
            end
        end

        // Count the character taken
        if (take)
        begin
            taken_count_next = taken_count_reg + 1'b1;
            if (chars_left_next != 7'd0)
            begin
                chars_left_next = chars_left_next - 7'd1;
            end
        end

        // Width or field limit used up by this digit
        if (digit_take && (chars_left_next == 7'd0 || taken_count_next >= LAST_TAKEN))
        begin
            emit     = 1'b1;
            consumed = 1'b1;
        end
    end

    // Raw result for the first result register
    always_comb
    begin
        r1_next.ok          = has_digit_next;
        r1_next.mag         = acc_next;
        r1_next.negative    = negative_next;
        r1_next.overflowed  = overflowed_next;
        r1_next.signed_mode = signed_mode_reg;
        r1_next.dest_size   = dest_size_reg;
        r1_next.length      = taken_count_next;
        r1_next.consumed    = consumed;
        r1_next.at_end      = at_end;
    end

    always_comb
    begin
        r1_valid_next = r1_valid_reg;
        if (accept && emit)
        begin
            r1_valid_next = 1'b1;
        end
        else if (r1_advance)
        begin
            r1_valid_next = 1'b0;
        end
    end

    // Saturation and truncation to the destination
    always_comb
    begin
        lim = '0;
        r   = '0;
        if (r1_reg.signed_mode)
        begin
            lim = (r1_reg.dest_size == DEST_64) ? 64'h8000_0000_0000_0000 : 64'h8000_0000;
            if (r1_reg.negative)
            begin
                r = (r1_reg.overflowed || r1_reg.mag > lim) ? lim : r1_reg.mag;
                r = 64'd0 - r;
            end
            else
            begin
                r = (r1_reg.overflowed || r1_reg.mag > lim - 64'd1) ? lim - 64'd1 : r1_reg.mag;
            end
        end
        else
        begin
            lim = (r1_reg.dest_size == DEST_64) ? '1 : 64'hFFFF_FFFF;
            if (r1_reg.overflowed || r1_reg.mag > lim)
            begin
                r = lim;
            end
            else
            begin
                r = r1_reg.negative ? 64'd0 - r1_reg.mag : r1_reg.mag;
            end
        end
        case (r1_reg.dest_size)
            DEST_8:  out_value_next = {56'd0, r[7:0]};
            DEST_16: out_value_next = {48'd0, r[15:0]};
            DEST_32: out_value_next = {32'd0, r[31:0]};
            default: out_value_next = r;
        endcase
        if (!r1_reg.ok)
        begin
            out_value_next = '0;
        end
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_mode_reg   <= BASE_DEC;
            max_chars_reg   <= 7'(FIELD_LIMIT);
            signed_mode_reg <= 1'b1;
            dest_size_reg   <= DEST_32;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_BASE_MODE:   base_mode_reg   <= base_t'(cfg_data[1:0]);
                REG_MAX_CHARS:   max_chars_reg   <= cfg_data;
                REG_SIGNED_MODE: signed_mode_reg <= cfg_data[0];
                REG_DEST_SIZE:   dest_size_reg   <= dest_t'(cfg_data[1:0]);
                default:         ;
            endcase
        end
    end

    // Scan state; a finished field returns to the whitespace phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_SKIP;
            chars_left_reg  <= 7'(FIELD_LIMIT);
            taken_count_reg <= '0;
            has_digit_reg   <= 1'b0;
            base_reg        <= BASE_AUTO;
            negative_reg    <= 1'b0;
            acc_reg         <= '0;
            overflowed_reg  <= 1'b0;
        end
        else if (accept)
        begin
            if (emit)
            begin
                phase_reg       <= PH_SKIP;
                chars_left_reg  <= max_chars_reg;
                taken_count_reg <= '0;
                has_digit_reg   <= 1'b0;
                base_reg        <= BASE_AUTO;
                negative_reg    <= 1'b0;
                acc_reg         <= '0;
                overflowed_reg  <= 1'b0;
            end
            else
            begin
                phase_reg       <= phase_next;
                chars_left_reg  <= chars_left_next;
                taken_count_reg <= taken_count_next;
                has_digit_reg   <= has_digit_next;
                base_reg        <= base_next;
                negative_reg    <= negative_next;
                acc_reg         <= acc_next;
                overflowed_reg  <= overflowed_next;
            end
        end
    end

    // Result registers: valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            r1_valid_reg <= r1_valid_next;
            if (out_ready)
            begin
                out_valid_reg <= r1_valid_reg;
            end
        end
    end

    // Result registers: payload
    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            r1_reg <= r1_next;
        end
        if (r1_advance)
        begin
            out_value_reg    <= out_value_next;
            out_len_reg      <= r1_reg.length;
            out_status_reg   <= !r1_reg.ok;
            out_consumed_reg <= r1_reg.consumed;
            out_at_end_reg   <= r1_reg.at_end;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-VALUE_W-LEN_W){1'b0}}, out_len_reg, out_value_reg};
    assign m_tuser  = {out_at_end_reg, out_consumed_reg, out_status_reg};

    // Input is held off while both result registers are full and stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        (r1_valid_reg && m_tvalid && !m_tready) |-> !s_tready)
        else $error("input taken while result path is full");

    // Whitespace phase holds a cleared field
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_SKIP) |-> (taken_count_reg == '0 && !has_digit_reg
            && !negative_reg && !overflowed_reg))
        else $error("field state not cleared in whitespace phase");

    // Overflow pins the accumulator at all ones
    assert property (@(posedge clk) disable iff (!rst_n)
        overflowed_reg |-> (acc_reg == '1))
        else $error("overflow without saturated accumulator");

    // A failed field carries a zero value
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> (m_tdata[VALUE_W-1:0] == '0))
        else $error("nonzero value on matching failure");

    // A consumed terminator never comes from end of input
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tuser[1] && m_tuser[2]))
        else $error("terminator consumed at end of input");

endmodule

`default_nettype wire
